### sv/pce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types and constant helpers for the peano curve encode unit.
// ----------------------------------------------------------------------------
package pce_pkg;

    typedef logic [1:0] t_trit;

    localparam t_trit TRIT_0 = 2'd0;
    localparam t_trit TRIT_1 = 2'd1;
    localparam t_trit TRIT_2 = 2'd2;

    // work carried from stage to stage
    typedef struct packed {
        logic [31:0] x;     // residual of x after the trits already taken
        logic [31:0] y;     // residual of y after the trits already taken
        logic [63:0] pos;   // position built so far
        logic        par_x; // parity of the x trit sum so far
        logic        par_y; // parity of the y trit sum so far
        logic        oor;   // coordinate out of range
    } t_work;

    // 3^n, evaluated at elaboration only
    function automatic logic [63:0] pow3(input int unsigned n);
        logic [63:0] acc;
        acc = 64'd1;
        for (int unsigned k = 0; k < n; k++) begin
            acc = acc * 64'd3;
        end
        return acc;
    endfunction

endpackage

### sv/pce_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_in_if
// Request channel of the peano curve encode unit: one point per request.
// ----------------------------------------------------------------------------
interface pce_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] coord_x;
    logic [31:0] coord_y;

    modport source (output valid, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

### sv/pce_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_out_if
// Response channel of the peano curve encode unit: one position per request.
// ----------------------------------------------------------------------------
interface pce_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] curve_position;
    logic        out_of_range;

    modport source (output valid, output curve_position, output out_of_range,
                    input ready);
    modport sink   (input valid, input curve_position, input out_of_range,
                    output ready);
endinterface

### sv/peano_curve_encode_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peano_curve_encode_unit
// Maps a 2D point to its index along the Peano space-filling curve.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  i_req     in   valid / ready    coord_x[31:0], coord_y[31:0]
//  o_rsp     out  valid / ready    curve_position[63:0], out_of_range
//
//  one request per cycle sustained while o_rsp is ready; one range stage
//  followed by one digit stage per trit of x and y
//  every stage has its own valid bit and takes new work when empty or moving,
//  so bubbles close up and requests enter while a response waits
//  synchronous active-low reset empties the pipeline; data registers not reset
// ----------------------------------------------------------------------------
module peano_curve_encode_unit #(
    parameter int NUM_TRITS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pce_in_if.sink     i_req,
    pce_out_if.source  o_rsp
);
    pce_pkg::t_work       w_data  [NUM_TRITS+1];
    logic [NUM_TRITS:0]   w_valid;
    logic [NUM_TRITS:0]   w_ready;

    pce_range_stage #(
        .NUM_TRITS (NUM_TRITS)
    ) u_range (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (i_req.valid),
        .i_coord_x  (i_req.coord_x),
        .i_coord_y  (i_req.coord_y),
        .o_up_ready (i_req.ready),
        .o_dn_valid (w_valid[0]),
        .o_dn_data  (w_data[0]),
        .i_dn_ready (w_ready[0])
    );

    for (genvar k = 0; k < NUM_TRITS; k++) begin : g_trit
        pce_trit_stage #(
            .EXP (NUM_TRITS - 1 - k)
        ) u_trit (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_up_valid (w_valid[k]),
            .i_up_data  (w_data[k]),
            .o_up_ready (w_ready[k]),
            .o_dn_valid (w_valid[k+1]),
            .o_dn_data  (w_data[k+1]),
            .i_dn_ready (w_ready[k+1])
        );
    end

    assign w_ready[NUM_TRITS]   = o_rsp.ready;
    assign o_rsp.valid          = w_valid[NUM_TRITS];
    // out-of-range points report position zero
    assign o_rsp.curve_position = w_data[NUM_TRITS].oor ? '0 : w_data[NUM_TRITS].pos;
    assign o_rsp.out_of_range   = w_data[NUM_TRITS].oor;
endmodule

### sv/pce_range_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_range_stage
// Entry stage: registers the point and flags coordinates of 3^NUM_TRITS or more.
// ----------------------------------------------------------------------------
module pce_range_stage #(
    parameter int NUM_TRITS = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_up_valid,
    input  logic [31:0]    i_coord_x,
    input  logic [31:0]    i_coord_y,
    output logic           o_up_ready,
    output logic           o_dn_valid,
    output pce_pkg::t_work o_dn_data,
    input  logic           i_dn_ready
);
    localparam logic [33:0] LIMIT = 34'(pce_pkg::pow3(NUM_TRITS));

    logic           r_valid;
    pce_pkg::t_work r_data;
    pce_pkg::t_work n_data;

    assign o_up_ready = !r_valid || i_dn_ready;

    always_comb begin
        n_data.x     = i_coord_x;
        n_data.y     = i_coord_y;
        n_data.pos   = '0;
        n_data.par_x = 1'b0;
        n_data.par_y = 1'b0;
        n_data.oor   = ({2'b00, i_coord_x} >= LIMIT) || ({2'b00, i_coord_y} >= LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_valid) begin
            r_data <= n_data;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_dn_data  = r_data;
endmodule

### sv/pce_trit_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_trit_stage
// One digit stage: takes the trit of weight 3^EXP from x and y, reflects it
// by the other coordinate's parity and appends both to the position.
// ----------------------------------------------------------------------------
module pce_trit_stage #(
    parameter int EXP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_up_valid,
    input  pce_pkg::t_work i_up_data,
    output logic           o_up_ready,
    output logic           o_dn_valid,
    output pce_pkg::t_work o_dn_data,
    input  logic           i_dn_ready
);
    localparam logic [32:0] P1 = 33'(pce_pkg::pow3(EXP));
    localparam logic [32:0] P2 = 33'(pce_pkg::pow3(EXP) << 1);

    logic           r_valid;
    pce_pkg::t_work r_data;
    pce_pkg::t_work n_data;

    pce_pkg::t_trit tx;
    pce_pkg::t_trit ty;
    pce_pkg::t_trit tx_m;
    pce_pkg::t_trit ty_m;
    logic [32:0]    sub_x;
    logic [32:0]    sub_y;
    logic [32:0]    diff_x;
    logic [32:0]    diff_y;
    logic           px;
    logic           py;

    assign o_up_ready = !r_valid || i_dn_ready;

    always_comb begin
        // digit extraction by compare against 2*3^e and 3^e
        if ({1'b0, i_up_data.x} >= P2) begin
            tx    = pce_pkg::TRIT_2;
            sub_x = P2;
        end else if ({1'b0, i_up_data.x} >= P1) begin
            tx    = pce_pkg::TRIT_1;
            sub_x = P1;
        end else begin
            tx    = pce_pkg::TRIT_0;
            sub_x = '0;
        end
        if ({1'b0, i_up_data.y} >= P2) begin
            ty    = pce_pkg::TRIT_2;
            sub_y = P2;
        end else if ({1'b0, i_up_data.y} >= P1) begin
            ty    = pce_pkg::TRIT_1;
            sub_y = P1;
        end else begin
            ty    = pce_pkg::TRIT_0;
            sub_y = '0;
        end
        diff_x = {1'b0, i_up_data.x} - sub_x;
        diff_y = {1'b0, i_up_data.y} - sub_y;

        // x trit reflects on odd y sum, y trit on odd x sum including this x trit
        tx_m = i_up_data.par_y ? (pce_pkg::TRIT_2 - tx) : tx;
        px   = i_up_data.par_x ^ (tx == pce_pkg::TRIT_1);
        ty_m = px ? (pce_pkg::TRIT_2 - ty) : ty;
        py   = i_up_data.par_y ^ (ty == pce_pkg::TRIT_1);

        n_data.x     = diff_x[31:0];
        n_data.y     = diff_y[31:0];
        n_data.pos   = (i_up_data.pos << 3) + i_up_data.pos
                     + 64'({tx_m, 1'b0}) + 64'(tx_m) + 64'(ty_m);
        n_data.par_x = px;
        n_data.par_y = py;
        n_data.oor   = i_up_data.oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_valid) begin
            r_data <= n_data;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_dn_data  = r_data;
endmodule

### sv/pce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_checker
// Port-level checks of the peano curve encode unit, bound to the top level.
// ----------------------------------------------------------------------------
module pce_checker #(
    parameter int NUM_TRITS = 20
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [63:0] i_curve_position,
    input logic        i_out_of_range
);
    localparam logic [63:0] POS_LIMIT = pce_pkg::pow3(2 * NUM_TRITS);
    localparam logic [7:0]  MAX_INFLIGHT = 8'(NUM_TRITS + 1);

    logic [7:0] r_cnt;
    logic [7:0] n_cnt;

    // requests taken but not yet answered
    always_comb begin
        n_cnt = r_cnt;
        if (i_req_valid && i_req_ready) begin
            n_cnt = n_cnt + 8'd1;
        end
        if (i_rsp_valid && i_rsp_ready) begin
            n_cnt = n_cnt - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_curve_position)
            && $stable(i_out_of_range))
        else $error("stalled response changed");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_cnt != 8'd0)
        else $error("response without a pending request");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_INFLIGHT)
        else $error("more requests in flight than pipeline stages");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_out_of_range |-> i_curve_position == 64'd0)
        else $error("out-of-range point with nonzero position");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_curve_position < POS_LIMIT)
        else $error("position beyond end of curve");
endmodule

bind peano_curve_encode_unit pce_checker #(
    .NUM_TRITS (NUM_TRITS)
) u_pce_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_curve_position (o_rsp.curve_position),
    .i_out_of_range   (o_rsp.out_of_range)
);

### verif/tb_peano_curve_encode_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peano_curve_encode_unit
// Self-checking bench for the peano curve encode unit. Drives a directed table
// of points, then about 550 random points of mixed shapes, through a
// valid/ready request channel. Every position that comes back is compared
// with the row's answer or an independent trit-by-trit curve model. Both
// sides idle at random, with a long back-pressure hold and a full drain pause.
// ----------------------------------------------------------------------------
module tb_peano_curve_encode_unit;

    // 3^n, used for the coordinate limit and the largest position
    function automatic logic [63:0] trit_span(input int n);
        logic [63:0] acc;
        int          k;
        acc = 64'd1;
        for (k = 0; k < n; k++) begin
            acc = acc * 64'd3;
        end
        return acc;
    endfunction

    localparam int          TRITS        = 20;
    localparam logic [63:0] COORD_LIMIT  = trit_span(TRITS);
    localparam logic [31:0] X_LIMIT      = COORD_LIMIT[31:0];
    localparam logic [63:0] MAX_POSITION = trit_span(2 * TRITS) - 64'd1;
    localparam int          RANDOM_POINTS = 550;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [63:0] pos;
        logic        oor;
    } t_curve_point;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        typed;
        logic [63:0] pos;
        logic        oor;
    } t_point_row;

    typedef enum int {
        SHAPE_SPREAD,
        SHAPE_LOW,
        SHAPE_TOP,
        SHAPE_ANY,
        SHAPE_OVER
    } t_coord_shape;

    localparam int DIRECTED_ROWS = 23;

    t_point_row point_table [DIRECTED_ROWS] = '{
        '{32'd0,         32'd0,         1'b1, 64'd0,        1'b0},
        '{X_LIMIT - 1,   X_LIMIT - 1,   1'b1, MAX_POSITION, 1'b0},
        '{X_LIMIT,       32'd0,         1'b1, 64'd0,        1'b1},
        '{32'd0,         X_LIMIT,       1'b1, 64'd0,        1'b1},
        '{X_LIMIT - 1,   X_LIMIT,       1'b1, 64'd0,        1'b1},
        '{32'hFFFFFFFF,  32'hFFFFFFFF,  1'b1, 64'd0,        1'b1},
        '{32'hFFFFFFFF,  32'd0,         1'b1, 64'd0,        1'b1},
        '{32'd0,         32'hFFFFFFFF,  1'b1, 64'd0,        1'b1},
        '{X_LIMIT - 1,   32'd0,         1'b0, 64'd0,        1'b0},
        '{32'd0,         X_LIMIT - 1,   1'b0, 64'd0,        1'b0},
        '{32'd1,         32'd0,         1'b0, 64'd0,        1'b0},
        '{32'd0,         32'd1,         1'b0, 64'd0,        1'b0},
        '{32'd1,         32'd1,         1'b0, 64'd0,        1'b0},
        '{32'd2,         32'd1,         1'b0, 64'd0,        1'b0},
        '{32'd1,         32'd2,         1'b0, 64'd0,        1'b0},
        '{32'd2,         32'd2,         1'b0, 64'd0,        1'b0},
        '{32'd3,         32'd0,         1'b0, 64'd0,        1'b0},
        '{32'd0,         32'd3,         1'b0, 64'd0,        1'b0},
        '{32'h80000000,  32'h7FFFFFFF,  1'b0, 64'd0,        1'b0},
        '{32'hAAAAAAAA,  32'h55555555,  1'b0, 64'd0,        1'b0},
        '{32'h55555555,  32'hAAAAAAAA,  1'b0, 64'd0,        1'b0},
        '{32'd59049,     32'd1162261467, 1'b0, 64'd0,       1'b0},
        '{X_LIMIT - 2,   32'd4,         1'b0, 64'd0,        1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pce_in_if  req_if ();
    pce_out_if rsp_if ();

    peano_curve_encode_unit #(
        .NUM_TRITS (TRITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_curve_point expected_positions [$];
    t_point_row   table_answers [$];

    int mismatches     = 0;
    int points_sent    = 0;
    int points_oor     = 0;
    int positions_seen = 0;
    int input_stalls   = 0;
    int cycle_count    = 0;

    // sender and receiver control, written with nonblocking assignments
    int holds_asked  = 0;
    int holds_taken  = 0;
    int hold_left    = 0;
    bit sink_steady  = 1'b0;
    bit sender_steady = 1'b0;

    always #5 i_clk = ~i_clk;

    // position along the curve, worked out one trit pair at a time
    function automatic t_curve_point peano_index(input logic [31:0] px,
                                                 input logic [31:0] py);
        t_curve_point   r;
        logic [63:0]    xv;
        logic [63:0]    yv;
        pce_pkg::t_trit x_digits [TRITS];
        pce_pkg::t_trit y_digits [TRITS];
        pce_pkg::t_trit t;
        logic           par_x;
        logic           par_y;
        int             k;
        xv    = {32'd0, px};
        yv    = {32'd0, py};
        r.pos = 64'd0;
        r.oor = 1'b0;
        par_x = 1'b0;
        par_y = 1'b0;
        if (xv >= COORD_LIMIT || yv >= COORD_LIMIT) begin
            r.oor = 1'b1;
            return r;
        end
        for (k = TRITS - 1; k >= 0; k--) begin
            x_digits[k] = pce_pkg::t_trit'(xv % 64'd3);
            y_digits[k] = pce_pkg::t_trit'(yv % 64'd3);
            xv = xv / 64'd3;
            yv = yv / 64'd3;
        end
        for (k = 0; k < TRITS; k++) begin
            t = x_digits[k];
            if (par_y) begin
                t = pce_pkg::TRIT_2 - t;
            end
            par_x = par_x ^ t[0];
            r.pos = r.pos * 64'd3 + 64'(t);
            t = y_digits[k];
            if (par_x) begin
                t = pce_pkg::TRIT_2 - t;
            end
            par_y = par_y ^ t[0];
            r.pos = r.pos * 64'd3 + 64'(t);
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_coord(input t_coord_shape shape);
        case (shape)
            SHAPE_SPREAD: return $urandom_range(X_LIMIT - 1, 0);
            SHAPE_LOW:    return $urandom_range(80, 0);
            SHAPE_TOP:    return X_LIMIT - 1 - $urandom_range(40, 0);
            SHAPE_OVER:   return X_LIMIT + $urandom_range(40, 0);
            default:      return $urandom;
        endcase
    endfunction

    function automatic t_coord_shape pick_shape();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 55) begin
            return SHAPE_SPREAD;
        end else if (roll < 68) begin
            return SHAPE_LOW;
        end else if (roll < 81) begin
            return SHAPE_TOP;
        end else if (roll < 95) begin
            return SHAPE_ANY;
        end
        return SHAPE_OVER;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // offer one point, idling first at random when the sender is not held steady
    task automatic send_point(input logic [31:0] x, input logic [31:0] y);
        while (!sender_steady && $urandom_range(99, 0) < 35) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.coord_x <= x;
        req_if.coord_y <= y;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // request and response monitor
    always @(posedge i_clk) begin : monitor
        t_curve_point e;
        t_point_row   row;
        if (i_rst_n) begin
            if (req_if.valid && !req_if.ready) begin
                input_stalls++;
            end
            if (req_if.valid && req_if.ready) begin
                e = peano_index(req_if.coord_x, req_if.coord_y);
                if (table_answers.size() > 0) begin
                    row = table_answers.pop_front();
                    if (row.typed) begin
                        e.pos = row.pos;
                        e.oor = row.oor;
                    end
                end
                expected_positions.push_back(e);
                points_sent++;
                if (e.oor) begin
                    points_oor++;
                end
            end
            if (rsp_if.valid && rsp_if.ready) begin
                positions_seen++;
                if (expected_positions.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    e = expected_positions.pop_front();
                    if (rsp_if.curve_position !== e.pos) begin
                        report_mismatch($sformatf("curve_position %0d, wanted %0d",
                                                  rsp_if.curve_position, e.pos));
                    end
                    if (rsp_if.out_of_range !== e.oor) begin
                        report_mismatch($sformatf("out_of_range %0b, wanted %0b",
                                                  rsp_if.out_of_range, e.oor));
                    end
                end
            end
        end
    end

    // response side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (holds_taken != holds_asked) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_taken  <= holds_taken + 1;
        end else if (sink_steady) begin
            rsp_if.ready <= 1'b1;
        end else begin
            rsp_if.ready <= ($urandom_range(99, 0) >= 35);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d requests outstanding",
                     cycle_count, expected_positions.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int i;
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.coord_x <= 32'd0;
        req_if.coord_y <= 32'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIRECTED_ROWS; i++) begin
            table_answers.push_back(point_table[i]);
            send_point(point_table[i].x, point_table[i].y);
        end

        for (i = 0; i < RANDOM_POINTS; i++) begin
            // long response hold while requests keep coming, so the pipe fills
            if (i == 120) begin
                holds_asked   <= holds_asked + 1;
                sender_steady <= 1'b1;
            end else if (i == 180) begin
                sender_steady <= 1'b0;
            end
            // drain pause: nothing offered until every response is back
            if (i == 250) begin
                req_if.valid <= 1'b0;
                do @(posedge i_clk); while (expected_positions.size() != 0);
            end
            if (i == 300) begin
                sender_steady <= 1'b1;
                sink_steady   <= 1'b1;
            end else if (i == 420) begin
                sender_steady <= 1'b0;
                sink_steady   <= 1'b0;
            end
            send_point(pick_coord(pick_shape()), pick_coord(pick_shape()));
        end
        req_if.valid <= 1'b0;

        do @(posedge i_clk); while (expected_positions.size() != 0);
        repeat (TRITS + 8) @(posedge i_clk);

        if (expected_positions.size() != 0) begin
            report_mismatch($sformatf("%0d requests never answered",
                                      expected_positions.size()));
        end

        $display("%0d points encoded (%0d out of range), %0d positions checked",
                 points_sent, points_oor, positions_seen);
        $display("request side stalled for %0d cycles under back-pressure",
                 input_stalls);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
